// ===== rtl/core/dma_register_decode_and_transfer_unit_macros.svh =====
// Assertion macros for the DMA register decode and transfer unit.
// Used by the top level only; depends on nothing else.
`ifndef DMA_REGISTER_DECODE_AND_TRANSFER_UNIT_MACROS_SVH
`define DMA_REGISTER_DECODE_AND_TRANSFER_UNIT_MACROS_SVH
`define DMA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/dma_pkg.sv =====
// Package for the DMA register decode and transfer unit.
// Holds command, result kind and state types; depends on nothing.
package dma_pkg;
  localparam logic [1:0] CmdCtrl = 2'd0;
  localparam logic [1:0] CmdStat = 2'd1;
  localparam logic [1:0] CmdStep = 2'd2;
  localparam logic [1:0] CmdData = 2'd3;
  localparam logic [1:0] KindStatus = 2'd0;
  localparam logic [1:0] KindRead   = 2'd1;
  localparam logic [1:0] KindWrite  = 2'd2;
  localparam logic [7:0] StatusBase  = 8'h1A;
  localparam logic [7:0] StatusNoEnd = 8'h20;
  localparam logic [7:0] OpReset   = 8'hC3;
  localparam logic [7:0] OpResetA  = 8'hC7;
  localparam logic [7:0] OpResetB  = 8'hCB;
  localparam logic [7:0] OpLoad    = 8'hCF;
  localparam logic [7:0] OpEnable  = 8'h87;
  localparam logic [7:0] OpDisable = 8'h83;
  localparam logic [3:0] GrpWr0 = 4'd0;
  localparam logic [3:0] GrpWr1 = 4'd1;
  localparam logic [3:0] GrpWr2 = 4'd2;
  localparam logic [3:0] GrpWr4 = 4'd4;
  localparam logic [3:0] GrpATime = 4'd10;

  typedef struct packed {
    logic [15:0] pa_start;
    logic [15:0] pb_start;
    logic [15:0] blen;
    logic        dir_ab;
    logic [1:0]  step_a;
    logic [1:0]  step_b;
    logic [2:0]  tim_a;
    logic [2:0]  tim_b;
    logic [15:0] live_a;
    logic [15:0] live_b;
    logic [16:0] remain;
    logic        active;
    logic        started;
    logic        ended;
    logic        collect;
    logic [3:0]  grp;
    logic [7:0]  pmask;
    logic [3:0]  pidx;
    logic        skip;
    logic        await_rd;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  byte_value;
    logic [2:0]  bus_cycles;
    logic        last;
  } result_t;

  function automatic logic [2:0] timing_code(input logic [7:0] b);
    case (b[1:0])
      2'd1: timing_code = 3'd3;
      2'd2: timing_code = 3'd2;
      default: timing_code = 3'd4;
    endcase
  endfunction

  function automatic logic [15:0] step_amount(input logic [1:0] c);
    case (c)
      2'd0: step_amount = 16'hFFFF;
      2'd1: step_amount = 16'd1;
      default: step_amount = 16'd0;
    endcase
  endfunction
endpackage

// ===== rtl/core/dma_register_decode_and_transfer_unit.sv =====
// Top level of the single-channel DMA register decode and transfer unit.
// Depends on dma_pkg, dma_decode and the assertion macro header.
// Each accepted input transfer is decoded combinationally against the register
// state; a result, if any, lands in an output register. One input transfer is
// taken every clock while the output register is empty or being drained, so
// the rate is one item per cycle, set by the single decode stage.
module dma_register_decode_and_transfer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  input  logic [7:0]  s_axis_tdata,  // data[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic [31:0] m_axis_tdata,  // address[15:0], byte_value[23:16], bus_cycles[26:24]
  output logic        m_axis_tlast
);
  import dma_pkg::*;
  `include "dma_register_decode_and_transfer_unit_macros.svh"

  state_t  st_q, st_d;
  result_t res_d, res_q;
  logic    acc;

  assign s_axis_tready = !res_q.valid || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  dma_decode u_dec (
    .st_i  (st_q),
    .cmd_i (s_axis_tuser),
    .data_i(s_axis_tdata),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{step_a: 2'd1, step_b: 2'd1, tim_a: 3'd3, tim_b: 3'd3, default: '0};
      res_q <= '0;
    end else begin
      if (acc) st_q <= st_d;
      if (acc) res_q <= res_d;
      else if (m_axis_tready) res_q.valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = res_q.valid;
  assign m_axis_tuser = res_q.kind;
  assign m_axis_tdata = {5'd0, res_q.bus_cycles, res_q.byte_value, res_q.address};
  assign m_axis_tlast = res_q.last;

  `DMA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result lost")
  `DMA_ASSERT_IMPL(a_last, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KindWrite, "bad last")
  `DMA_ASSERT_IMPL(a_end, m_axis_tvalid && m_axis_tlast, st_q.ended && !st_q.active, "end flags")
endmodule

// ===== rtl/core/dma_decode.sv =====
// Next-state and result logic for one input transfer of the DMA unit.
// Depends on dma_pkg.
module dma_decode (
  input  dma_pkg::state_t  st_i,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       data_i,
  output dma_pkg::state_t  st_o,
  output dma_pkg::result_t res_o
);
  import dma_pkg::*;

  logic [3:0] idx;
  logic       found;
  logic [7:0] d;

  always_comb begin
    d = data_i;
    idx = 4'd8;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (st_i.pmask[i] && (4'(i) >= st_i.pidx)) begin
        idx = 4'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    st_o = st_i;
    res_o = '0;
    case (cmd_i)
      CmdCtrl: begin
        if (st_i.skip) begin
          st_o.skip = 1'b0;
          st_o.collect = 1'b0;
        end else if (st_i.collect) begin
          if (!found) begin
            st_o.collect = 1'b0;
            st_o.pidx = 4'd8;
          end else begin
            st_o.pmask = st_i.pmask & ~(8'd1 << idx[2:0]);
            st_o.pidx = idx + 4'd1;
            if (st_o.pmask == 8'd0) st_o.collect = 1'b0;
            case (st_i.grp)
              GrpWr0: begin
                case (idx)
                  4'd0: st_o.pa_start[7:0] = d;
                  4'd1: st_o.pa_start[15:8] = d;
                  4'd2: st_o.blen[7:0] = d;
                  4'd3: st_o.blen[15:8] = d;
                  default: ;
                endcase
              end
              GrpWr1: begin
                st_o.tim_a = timing_code(d);
                if (d[5]) begin
                  st_o.collect = 1'b1;
                  st_o.grp = GrpATime;
                  st_o.pmask = 8'd1;
                  st_o.pidx = 4'd0;
                end
              end
              GrpWr2: begin
                st_o.tim_b = timing_code(d);
                if (d[5]) st_o.skip = 1'b1;
              end
              GrpWr4: begin
                if (idx == 4'd0) st_o.pb_start[7:0] = d;
                else if (idx == 4'd1) st_o.pb_start[15:8] = d;
              end
              default: ;
            endcase
          end
        end else if ((d & 8'h83) == 8'h83) begin
          case (d)
            OpReset: begin
              st_o.active = 1'b0;
              st_o.started = 1'b0;
              st_o.ended = 1'b0;
              st_o.tim_a = 3'd3;
              st_o.tim_b = 3'd3;
              st_o.collect = 1'b0;
              st_o.await_rd = 1'b0;
            end
            OpResetA: st_o.tim_a = 3'd3;
            OpResetB: st_o.tim_b = 3'd3;
            OpLoad: begin
              st_o.live_a = st_i.pa_start;
              st_o.live_b = st_i.pb_start;
              st_o.remain = {1'b0, st_i.blen} + 17'd1;
              st_o.ended = 1'b0;
            end
            OpEnable: begin
              st_o.active = (st_i.remain != 17'd0);
              if (st_i.remain == 17'd0) st_o.ended = 1'b1;
            end
            OpDisable: st_o.active = 1'b0;
            default: ;
          endcase
        end else if ((d & 8'hC7) == 8'h82) begin
        end else if ((d & 8'h83) == 8'h81) begin
          st_o.pmask = {6'd0, d[3:2]};
          if (d[3:2] != 2'd0) begin
            st_o.collect = 1'b1;
            st_o.grp = GrpWr4;
            st_o.pidx = 4'd0;
          end
        end else if ((d & 8'h83) == 8'h80) begin
        end else if ((d & 8'h87) == 8'h04) begin
          st_o.step_a = d[5:4];
          if (d[6]) begin
            st_o.collect = 1'b1;
            st_o.grp = GrpWr1;
            st_o.pmask = 8'd1;
            st_o.pidx = 4'd0;
          end
        end else if ((d & 8'h87) == 8'h00) begin
          st_o.step_b = d[5:4];
          if (d[6]) begin
            st_o.collect = 1'b1;
            st_o.grp = GrpWr2;
            st_o.pmask = 8'd1;
            st_o.pidx = 4'd0;
          end
        end else if (!d[7]) begin
          st_o.dir_ab = d[2];
          st_o.pmask = {4'd0, d[6:3]};
          if (d[6:3] != 4'd0) begin
            st_o.collect = 1'b1;
            st_o.grp = GrpWr0;
            st_o.pidx = 4'd0;
          end
        end
      end
      CmdStat: begin
        res_o.valid = 1'b1;
        res_o.kind = KindStatus;
        res_o.byte_value = StatusBase | (st_i.ended ? 8'd0 : StatusNoEnd)
                         | {7'd0, st_i.started};
      end
      CmdStep: begin
        if (st_i.active && st_i.remain != 17'd0 && !st_i.await_rd) begin
          st_o.started = 1'b1;
          st_o.await_rd = 1'b1;
          res_o.valid = 1'b1;
          res_o.kind = KindRead;
          res_o.address = st_i.dir_ab ? st_i.live_a : st_i.live_b;
          res_o.bus_cycles = st_i.dir_ab ? st_i.tim_a : st_i.tim_b;
        end
      end
      default: begin
        if (st_i.await_rd) begin
          st_o.await_rd = 1'b0;
          res_o.valid = 1'b1;
          res_o.kind = KindWrite;
          res_o.address = st_i.dir_ab ? st_i.live_b : st_i.live_a;
          res_o.byte_value = d;
          res_o.bus_cycles = st_i.dir_ab ? st_i.tim_b : st_i.tim_a;
          st_o.live_a = st_i.live_a + step_amount(st_i.step_a);
          st_o.live_b = st_i.live_b + step_amount(st_i.step_b);
          if (st_i.remain != 17'd0) st_o.remain = st_i.remain - 17'd1;
          if (st_o.remain == 17'd0) begin
            st_o.ended = 1'b1;
            st_o.active = 1'b0;
            res_o.last = 1'b1;
          end
        end
      end
    endcase
  end
endmodule

// ===== tb/sv/dma_register_decode_and_transfer_unit_tb.sv =====
// Self-checking testbench for the DMA register decode and transfer unit.
// Drives command and data transfers, predicts each result and checks it.
// Depends on dma_pkg and the top level only.
`timescale 1ns / 1ps

module dma_register_decode_and_transfer_unit_tb;
  import dma_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  byte_value;
    logic [2:0]  bus_cycles;
    logic        last;
  } dma_res_t;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    bit         known;
    dma_res_t   res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  dma_register_decode_and_transfer_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted register file of the controller.
  logic [15:0] pa_start, pb_start, blen, live_a, live_b;
  logic        dir_ab, active, started, ended, collecting, skip_next, await_rd;
  logic [1:0]  step_a, step_b;
  logic [2:0]  tim_a, tim_b;
  logic [16:0] remain;
  logic [3:0]  grp, pidx;
  logic [7:0]  pmask;

  dma_res_t expected_results[$];
  int       errors = 0;
  int       send_idle = 22, recv_idle = 75;
  bit       hold_off = 1'b0;
  bit       done = 1'b0;
  longint   cycles = 0;

  function automatic logic [2:0] decode_timing(logic [7:0] b);
    case (b[1:0])
      2'd1: return 3'd3;
      2'd2: return 3'd2;
      default: return 3'd4;
    endcase
  endfunction

  function automatic logic [15:0] addr_delta(logic [1:0] c);
    if (c == 2'd0) return 16'hFFFF;
    if (c == 2'd1) return 16'd1;
    return 16'd0;
  endfunction

  function automatic void clear_regs();
    pa_start = '0; pb_start = '0; blen = '0; dir_ab = 1'b0;
    step_a = 2'd1; step_b = 2'd1; tim_a = 3'd3; tim_b = 3'd3;
    live_a = '0; live_b = '0; remain = '0;
    active = 1'b0; started = 1'b0; ended = 1'b0; collecting = 1'b0;
    grp = '0; pmask = '0; pidx = '0; skip_next = 1'b0; await_rd = 1'b0;
  endfunction

  function automatic void open_group(logic [3:0] g, logic [7:0] m);
    collecting = 1'b1; grp = g; pmask = m; pidx = 4'd0;
  endfunction

  function automatic void take_param(logic [7:0] d);
    while (pidx < 4'd8 && !pmask[pidx[2:0]]) pidx++;
    if (pidx >= 4'd8) begin
      collecting = 1'b0;
      return;
    end
    case (grp)
      GrpWr0: begin
        case (pidx)
          4'd0: pa_start[7:0] = d;
          4'd1: pa_start[15:8] = d;
          4'd2: blen[7:0] = d;
          4'd3: blen[15:8] = d;
          default: ;
        endcase
      end
      GrpWr1: begin
        tim_a = decode_timing(d);
        if (d[5]) begin
          open_group(GrpATime, 8'd1);
          return;
        end
      end
      GrpWr2: begin
        tim_b = decode_timing(d);
        if (d[5]) skip_next = 1'b1;
      end
      GrpWr4: begin
        if (pidx == 4'd0) pb_start[7:0] = d;
        else if (pidx == 4'd1) pb_start[15:8] = d;
      end
      default: ;
    endcase
    pmask[pidx[2:0]] = 1'b0;
    pidx++;
    if (pmask == 8'd0) collecting = 1'b0;
  endfunction

  function automatic void run_command(logic [7:0] c);
    case (c)
      OpReset: begin
        active = 1'b0; started = 1'b0; ended = 1'b0; tim_a = 3'd3; tim_b = 3'd3;
        collecting = 1'b0; await_rd = 1'b0;
      end
      OpResetA: tim_a = 3'd3;
      OpResetB: tim_b = 3'd3;
      OpLoad: begin
        live_a = pa_start; live_b = pb_start; remain = {1'b0, blen} + 17'd1;
        ended = 1'b0;
      end
      OpEnable: begin
        active = 1'b1;
        if (remain == 17'd0) begin
          ended = 1'b1; active = 1'b0;
        end
      end
      OpDisable: active = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void decode_ctrl(logic [7:0] d);
    if (skip_next) begin
      skip_next = 1'b0; collecting = 1'b0;
    end else if (collecting) take_param(d);
    else if ((d & 8'h83) == 8'h83) run_command(d);
    else if ((d & 8'hC7) == 8'h82) ;
    else if ((d & 8'h83) == 8'h81) begin
      pmask = {6'd0, d[3:2]};
      if (d[3:2] != 2'd0) open_group(GrpWr4, {6'd0, d[3:2]});
    end else if ((d & 8'h83) == 8'h80) ;
    else if ((d & 8'h87) == 8'h04) begin
      step_a = d[5:4];
      if (d[6]) open_group(GrpWr1, 8'd1);
    end else if ((d & 8'h87) == 8'h00) begin
      step_b = d[5:4];
      if (d[6]) open_group(GrpWr2, 8'd1);
    end else if (!d[7]) begin
      dir_ab = d[2];
      pmask = {4'd0, d[6:3]};
      if (d[6:3] != 4'd0) open_group(GrpWr0, {4'd0, d[6:3]});
    end
  endfunction

  // Advances the predicted state by one input and returns whether a result follows.
  function automatic bit predict_dma(logic [1:0] cmd, logic [7:0] d, output dma_res_t r);
    r = '0;
    case (cmd)
      CmdCtrl: begin
        decode_ctrl(d);
        return 0;
      end
      CmdStat: begin
        r.kind = KindStatus;
        r.byte_value = StatusBase | (ended ? 8'h00 : StatusNoEnd) | {7'd0, started};
        return 1;
      end
      CmdStep: begin
        if (!active || remain == 17'd0 || await_rd) return 0;
        started = 1'b1; await_rd = 1'b1;
        r.kind = KindRead;
        r.address = dir_ab ? live_a : live_b;
        r.bus_cycles = dir_ab ? tim_a : tim_b;
        return 1;
      end
      default: begin
        if (!await_rd) return 0;
        await_rd = 1'b0;
        r.kind = KindWrite;
        r.address = dir_ab ? live_b : live_a;
        r.byte_value = d;
        r.bus_cycles = dir_ab ? tim_b : tim_a;
        live_a += addr_delta(step_a);
        live_b += addr_delta(step_b);
        if (remain > 17'd0) remain--;
        if (remain == 17'd0) begin
          ended = 1'b1; active = 1'b0; r.last = 1'b1;
        end
        return 1;
      end
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [7:0] d, bit known = 0,
                           dma_res_t want = '0);
    dma_res_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_dma(cmd, d, r)) begin
      if (known && r !== want) begin
        $display("%0t table row mismatch: expected %h actual %h", $time, want, r);
        errors++;
      end
      expected_results.push_back(r);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    dma_res_t got, want;
    cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tdata[26:24],
             m_axis_tlast};
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
          $display("%0t kind: expected %0d actual %0d", $time, want.kind, got.kind);
        if (got.address !== want.address)
          $display("%0t address: expected %h actual %h", $time, want.address, got.address);
        if (got.byte_value !== want.byte_value)
          $display("%0t byte: expected %h actual %h", $time, want.byte_value, got.byte_value);
        if (got.bus_cycles !== want.bus_cycles)
          $display("%0t cycles: expected %0d actual %0d", $time, want.bus_cycles,
                   got.bus_cycles);
        if (got.last !== want.last)
          $display("%0t last: expected %0d actual %0d", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
    m_axis_tready <= !hold_off && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin
    if (cycles > 400000 && !done) begin
      $display("[dma_register_decode_and_transfer_unit] ERROR");
      $finish;
    end
  end

  // Long receiver stall, counted here, while the sender keeps offering.
  initial begin
    wait (hold_off);
    repeat (60) @(posedge clk_i);
    hold_off = 1'b0;
  end

  function automatic dma_res_t status_res(logic [7:0] b);
    dma_res_t r;
    r = '0; r.kind = KindStatus; r.byte_value = b;
    return r;
  endfunction

  // One well-formed block program: WR0, WR1/WR2 timings, WR4, load, enable, steps, status.
  task automatic random_block();
    int n;
    logic [7:0] d;
    send_item(CmdCtrl, {1'b0, 4'b1111, 1'($urandom_range(1)), 2'b01});
    send_item(CmdCtrl, 8'($urandom));
    send_item(CmdCtrl, 8'($urandom));
    send_item(CmdCtrl, 8'($urandom_range(5)));
    send_item(CmdCtrl, 8'd0);
    d = {1'b0, 1'b1, 2'($urandom), 4'b0100};
    send_item(CmdCtrl, d);
    d = 8'($urandom);
    send_item(CmdCtrl, d);
    if (d[5]) send_item(CmdCtrl, 8'($urandom));
    send_item(CmdCtrl, {1'b0, 1'b1, 2'($urandom), 4'b0000});
    d = 8'($urandom);
    send_item(CmdCtrl, d);
    if (d[5]) send_item(CmdCtrl, 8'($urandom));
    send_item(CmdCtrl, 8'hAD);
    send_item(CmdCtrl, 8'($urandom));
    send_item(CmdCtrl, 8'($urandom));
    send_item(CmdCtrl, OpLoad);
    send_item(CmdCtrl, OpEnable);
    n = $urandom_range(12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_item(2'($urandom), 8'($urandom));
      send_item(CmdStep, 8'($urandom));
      send_item(CmdData, 8'($urandom));
    end
    send_item(CmdStat, 8'd0);
  endtask

  initial begin
    stim_row_t rows[$];
    int        phase_items;
    clear_regs();
    rows.push_back('{CmdStat, 8'hFF, 1, status_res(8'h3A)});
    rows.push_back('{CmdStep, 8'h00, 0, '0});
    rows.push_back('{CmdData, 8'hFF, 0, '0});
    rows.push_back('{CmdCtrl, OpEnable, 0, '0});
    rows.push_back('{CmdStat, 8'h00, 1, status_res(8'h1A)});
    rows.push_back('{CmdCtrl, 8'h7D, 0, '0});
    rows.push_back('{CmdCtrl, 8'hFF, 0, '0});
    rows.push_back('{CmdCtrl, 8'hFF, 0, '0});
    rows.push_back('{CmdCtrl, 8'h01, 0, '0});
    rows.push_back('{CmdCtrl, 8'h00, 0, '0});
    rows.push_back('{CmdCtrl, 8'h8D, 0, '0});
    rows.push_back('{CmdCtrl, 8'h00, 0, '0});
    rows.push_back('{CmdCtrl, 8'h00, 0, '0});
    rows.push_back('{CmdCtrl, OpLoad, 0, '0});
    rows.push_back('{CmdCtrl, OpEnable, 0, '0});
    rows.push_back('{CmdStep, 8'h00, 0, '0});
    rows.push_back('{CmdStep, 8'h00, 0, '0});
    rows.push_back('{CmdCtrl, OpDisable, 0, '0});
    rows.push_back('{CmdData, 8'hA5, 0, '0});
    rows.push_back('{CmdCtrl, OpEnable, 0, '0});
    rows.push_back('{CmdStep, 8'h00, 0, '0});
    rows.push_back('{CmdCtrl, OpReset, 0, '0});
    rows.push_back('{CmdData, 8'h5A, 0, '0});
    rows.push_back('{CmdCtrl, OpResetA, 0, '0});
    rows.push_back('{CmdCtrl, OpResetB, 0, '0});
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].cmd, rows[i].data, rows[i].known, rows[i].res);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 22 : (ph == 1) ? 75 : 0;
      recv_idle = (ph == 0) ? 75 : (ph == 1) ? 22 : 0;
      if (ph == 2) hold_off = 1'b1;
      phase_items = 0;
      while (phase_items < 440) begin
        if ($urandom_range(4) == 0) begin
          send_item(2'($urandom), 8'($urandom));
          phase_items++;
        end else begin
          random_block();
          phase_items += 30;
        end
      end
    end
    drain();
    done = 1'b1;
    if (errors == 0 && expected_results.size() == 0)
      $display("[dma_register_decode_and_transfer_unit] OK");
    else
      $display("[dma_register_decode_and_transfer_unit] ERROR");
    $finish;
  end
endmodule
